/* hdl/rvc_pkg.sv */
// Shared types and constants of the RV32I decode and execute core.
// Holds the item and result payloads, the decoded instruction and status codes.
// No dependencies.
package rvc_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ILLEGAL  = 3'd1;
  localparam logic [2:0] ST_MEM      = 3'd2;
  localparam logic [2:0] ST_ECALL    = 3'd3;
  localparam logic [2:0] ST_SEMIHOST = 3'd4;
  localparam logic [2:0] ST_HALTED   = 3'd5;
  localparam logic [2:0] ST_PRELOAD  = 3'd6;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
  localparam logic [6:0]  F7_ALT      = 7'h20;

  typedef enum logic [3:0] {
    C_ALU_R, C_ALU_I, C_LOAD, C_STORE, C_BRANCH, C_LUI, C_AUIPC,
    C_JAL, C_JALR, C_ECALL, C_EBREAK, C_ILLEGAL, C_PRELOAD
  } cls_e;

  typedef enum logic [3:0] {
    A_ADD, A_SUB, A_SLL, A_SLT, A_SLTU, A_XOR, A_SRL, A_SRA, A_OR, A_AND
  } alu_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] instr_word;
    logic [15:0] preload_addr;
    logic [7:0]  preload_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic        reg_write_enable;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
  } result_t;

  typedef struct packed {
    cls_e        cls;
    alu_e        alu;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic        mark_start;
    logic        mark_end;
    logic [15:0] preload_addr;
    logic [7:0]  preload_byte;
  } dec_t;

endpackage

/* hdl/rv32i_decode_execute_core.sv */
// Top level of the RV32I decode and execute core.
// Joins the configuration port, front end, entry queue and back end. Depends on rvc_pkg.
//
// Each accepted item yields one result. In the back end an instruction passes through
// a register file read state, then an execute and retire state; an in-window load adds
// a state for the registered read of the four byte-wide data memory banks. A preload,
// or any instruction while halted, retires from the read state. The front end decodes
// on the accept edge and a two-entry queue holds decoded items, so push is taken while
// the back end works and while a result waits to be popped. After reset the data memory
// is cleared one four-byte row per cycle over MEM_BYTES/4 rows, with full held high;
// configuration writes are taken meanwhile. MEM_BYTES must be a power of two (unchecked).
module rv32i_decode_execute_core #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             push,
  output logic             full,
  input  rvc_pkg::item_t   item_i,
  output logic             empty,
  input  logic             pop,
  output rvc_pkg::result_t result_o
);

  localparam logic REG_ENTRY_PC = 1'b0;
  localparam logic REG_MEM_BASE = 1'b1;

  logic [31:0]   entry_pc_q;
  logic [31:0]   mem_base_q;
  logic          cfg_we;
  logic          fifo_full, fifo_push, fifo_valid, fifo_pop, busy;
  rvc_pkg::dec_t dec, head;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_MEM_BASE) ? mem_base_q : entry_pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_pc_q <= 32'd0;
      mem_base_q <= 32'd0;
    end else if (cfg_we) begin
      if (paddr[2] == REG_ENTRY_PC) entry_pc_q <= pwdata;
      else mem_base_q <= pwdata;
    end
  end

  rvc_front u_front (
    .item_i      (item_i),
    .push_i      (push),
    .fifo_full_i (fifo_full),
    .busy_i      (busy),
    .full_o      (full),
    .fifo_push_o (fifo_push),
    .dec_o       (dec)
  );

  rvc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (dec),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .rdata_o (head)
  );

  rvc_back #(
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (fifo_valid),
    .head_pop_o   (fifo_pop),
    .busy_o       (busy),
    .cfg_pc_we_i  (cfg_we && paddr[2] == REG_ENTRY_PC),
    .cfg_pc_i     (pwdata),
    .mem_base_i   (mem_base_q),
    .pop_i        (pop),
    .empty_o      (empty),
    .result_o     (result_o)
  );

endmodule

/* hdl/rvc_front.sv */
// Front end: accepts input items and classifies instruction words.
// Produces one decoded entry per accepted item. Depends on rvc_pkg.
module rvc_front (
  input  rvc_pkg::item_t item_i,
  input  logic           push_i,
  input  logic           fifo_full_i,
  input  logic           busy_i,
  output logic           full_o,
  output logic           fifo_push_o,
  output rvc_pkg::dec_t  dec_o
);

  logic [31:0] w;
  logic [6:0]  op;
  logic [6:0]  f7;
  logic [2:0]  f3;
  logic [31:0] immi;
  rvc_pkg::alu_e f3_alu;

  assign full_o      = fifo_full_i | busy_i;
  assign fifo_push_o = push_i & ~full_o;

  always_comb begin
    w    = item_i.instr_word;
    op   = w[6:0];
    f3   = w[14:12];
    f7   = w[31:25];
    immi = {{20{w[31]}}, w[31:20]};
    case (f3)
      3'd0: f3_alu = rvc_pkg::A_ADD;
      3'd1: f3_alu = rvc_pkg::A_SLL;
      3'd2: f3_alu = rvc_pkg::A_SLT;
      3'd3: f3_alu = rvc_pkg::A_SLTU;
      3'd4: f3_alu = rvc_pkg::A_XOR;
      3'd5: f3_alu = rvc_pkg::A_SRL;
      3'd6: f3_alu = rvc_pkg::A_OR;
      default: f3_alu = rvc_pkg::A_AND;
    endcase

    dec_o              = '0;
    dec_o.cls          = rvc_pkg::C_ILLEGAL;
    dec_o.alu          = f3_alu;
    dec_o.f3           = f3;
    dec_o.rd           = w[11:7];
    dec_o.rs1          = w[19:15];
    dec_o.rs2          = w[24:20];
    dec_o.imm          = immi;
    dec_o.preload_addr = item_i.preload_addr;
    dec_o.preload_byte = item_i.preload_byte;

    if (item_i.operation) begin
      dec_o.cls = rvc_pkg::C_PRELOAD;
    end else begin
      case (op)
        rvc_pkg::OP_REG: begin
          if (f7 == rvc_pkg::F7_ALT && f3 == 3'd0) begin
            dec_o.cls = rvc_pkg::C_ALU_R;
            dec_o.alu = rvc_pkg::A_SUB;
          end else if (f7 == rvc_pkg::F7_ALT && f3 == 3'd5) begin
            dec_o.cls = rvc_pkg::C_ALU_R;
            dec_o.alu = rvc_pkg::A_SRA;
          end else if (f7 == 7'd0) begin
            dec_o.cls = rvc_pkg::C_ALU_R;
          end
        end
        rvc_pkg::OP_IMM: begin
          if (f3 == 3'd1) begin
            if (f7 == 7'd0) begin
              dec_o.cls        = rvc_pkg::C_ALU_I;
              dec_o.mark_start = (w[11:7] == 5'd0) && (w[19:15] == 5'd0) &&
                                 (w[24:20] == 5'd31);
            end
          end else if (f3 == 3'd5) begin
            if (f7 == 7'd0) begin
              dec_o.cls = rvc_pkg::C_ALU_I;
            end else if (f7 == rvc_pkg::F7_ALT) begin
              dec_o.cls      = rvc_pkg::C_ALU_I;
              dec_o.alu      = rvc_pkg::A_SRA;
              dec_o.mark_end = (w[11:7] == 5'd0) && (w[19:15] == 5'd0) &&
                               (w[24:20] == 5'd7);
            end
          end else begin
            dec_o.cls = rvc_pkg::C_ALU_I;
          end
        end
        rvc_pkg::OP_LOAD: begin
          if (f3 != 3'd3 && f3 < 3'd6) dec_o.cls = rvc_pkg::C_LOAD;
        end
        rvc_pkg::OP_STORE: begin
          if (f3 <= 3'd2) dec_o.cls = rvc_pkg::C_STORE;
          dec_o.imm = {{20{w[31]}}, w[31:25], w[11:7]};
        end
        rvc_pkg::OP_BRANCH: begin
          if (f3 != 3'd2 && f3 != 3'd3) dec_o.cls = rvc_pkg::C_BRANCH;
          dec_o.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        end
        rvc_pkg::OP_LUI: begin
          dec_o.cls = rvc_pkg::C_LUI;
          dec_o.imm = {w[31:12], 12'd0};
        end
        rvc_pkg::OP_AUIPC: begin
          dec_o.cls = rvc_pkg::C_AUIPC;
          dec_o.imm = {w[31:12], 12'd0};
        end
        rvc_pkg::OP_JAL: begin
          dec_o.cls = rvc_pkg::C_JAL;
          dec_o.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
        rvc_pkg::OP_JALR: begin
          if (f3 == 3'd0) dec_o.cls = rvc_pkg::C_JALR;
        end
        rvc_pkg::OP_SYSTEM: begin
          if (w == rvc_pkg::WORD_ECALL) dec_o.cls = rvc_pkg::C_ECALL;
          else if (w == rvc_pkg::WORD_EBREAK) dec_o.cls = rvc_pkg::C_EBREAK;
        end
        default: dec_o.cls = rvc_pkg::C_ILLEGAL;
      endcase
    end
  end

endmodule

/* hdl/rvc_fifo.sv */
// Two-entry queue of decoded entries between the front and back ends.
// Depends on rvc_pkg.
module rvc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rvc_pkg::dec_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output rvc_pkg::dec_t rdata_o
);

  rvc_pkg::dec_t mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule

/* hdl/rvc_back.sv */
// Back end: register file, pc, data memory and execution of decoded entries.
// Holds the result register and the memory clearing pass. Depends on rvc_pkg.
module rvc_back #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rvc_pkg::dec_t    head_i,
  input  logic             head_valid_i,
  output logic             head_pop_o,
  output logic             busy_o,
  input  logic             cfg_pc_we_i,
  input  logic [31:0]      cfg_pc_i,
  input  logic [31:0]      mem_base_i,
  input  logic             pop_i,
  output logic             empty_o,
  output rvc_pkg::result_t result_o
);

  localparam int unsigned ROWS = MEM_BYTES / 4;
  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam int unsigned RW   = $clog2(ROWS);
  localparam logic [32:0] LIM  = 33'(MEM_BYTES);

  typedef enum logic [1:0] {S_RD, S_EX, S_LD} state_e;

  state_e      state_q, state_d;
  logic [31:0] pc_q;
  logic        halted_q;
  logic [1:0]  phase_q;
  logic        out_valid_q;
  rvc_pkg::result_t out_q;
  logic [31:0] rf_q [32];
  logic [31:0] rf_valid_q;
  logic [31:0] a_raw_q, b_raw_q;
  logic        a_ok_q, b_ok_q;
  logic        clr_q;
  logic [RW-1:0] clr_row_q;
  logic [1:0]  ld_off_q;
  logic [7:0]  rdata [4];

  rvc_pkg::dec_t h;
  logic [31:0] a, b, op_b, alu_res, eff, off32, npc, val, ld_raw, ld_val;
  logic [32:0] span;
  logic [2:0]  nbytes, st;
  logic [1:0]  ph_n;
  logic        out_free, commit, rd_issue, go_ld, wr, take, in_win, fault, exec;
  logic        pre_ok, pre_wr, st_wr;
  logic [31:0] pre_off;

  assign h        = head_i;
  assign a        = a_ok_q ? a_raw_q : 32'd0;
  assign b        = b_ok_q ? b_raw_q : 32'd0;
  assign out_free = ~out_valid_q | pop_i;
  assign busy_o   = clr_q;
  assign empty_o  = ~out_valid_q;
  assign result_o = out_q;
  assign pre_off  = {16'd0, h.preload_addr};
  assign pre_ok   = pre_off < 32'(MEM_BYTES);

  always_comb begin
    op_b = (h.cls == rvc_pkg::C_ALU_I) ? h.imm : b;
    case (h.alu)
      rvc_pkg::A_ADD:  alu_res = a + op_b;
      rvc_pkg::A_SUB:  alu_res = a - op_b;
      rvc_pkg::A_SLL:  alu_res = a << op_b[4:0];
      rvc_pkg::A_SLT:  alu_res = {31'd0, $signed(a) < $signed(op_b)};
      rvc_pkg::A_SLTU: alu_res = {31'd0, a < op_b};
      rvc_pkg::A_XOR:  alu_res = a ^ op_b;
      rvc_pkg::A_SRL:  alu_res = a >> op_b[4:0];
      rvc_pkg::A_SRA:  alu_res = 32'($signed(a) >>> op_b[4:0]);
      rvc_pkg::A_OR:   alu_res = a | op_b;
      default:         alu_res = a & op_b;
    endcase
    case (h.f3)
      3'd0: take = a == b;
      3'd1: take = a != b;
      3'd4: take = $signed(a) < $signed(b);
      3'd5: take = $signed(a) >= $signed(b);
      3'd6: take = a < b;
      3'd7: take = a >= b;
      default: take = 1'b0;
    endcase
    case (h.f3[1:0])
      2'd0: nbytes = 3'd1;
      2'd1: nbytes = 3'd2;
      default: nbytes = 3'd4;
    endcase
    eff    = a + h.imm;
    off32  = eff - mem_base_i;
    span   = {1'b0, off32} + {30'd0, nbytes};
    in_win = span <= LIM;
    for (int i = 0; i < 4; i++) begin
      ld_raw[8*i +: 8] = rdata[2'(ld_off_q + 2'(i))];
    end
    case (h.f3)
      3'd0: ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
      3'd1: ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
      3'd4: ld_val = {24'd0, ld_raw[7:0]};
      3'd5: ld_val = {16'd0, ld_raw[15:0]};
      default: ld_val = ld_raw;
    endcase
  end

  always_comb begin
    st   = rvc_pkg::ST_OK;
    wr   = 1'b0;
    val  = 32'd0;
    npc  = pc_q + 32'd4;
    ph_n = 2'd0;
    case (h.cls)
      rvc_pkg::C_ALU_R, rvc_pkg::C_ALU_I: begin
        wr   = 1'b1;
        val  = alu_res;
        ph_n = h.mark_start ? 2'd1 : 2'd0;
        if (h.mark_end && phase_q == 2'd2) st = rvc_pkg::ST_SEMIHOST;
      end
      rvc_pkg::C_LOAD: begin
        if (!in_win) begin
          st = rvc_pkg::ST_MEM;
        end else begin
          wr  = 1'b1;
          val = ld_val;
        end
      end
      rvc_pkg::C_STORE: begin
        if (!in_win) st = rvc_pkg::ST_MEM;
      end
      rvc_pkg::C_BRANCH: begin
        if (take) npc = pc_q + h.imm;
      end
      rvc_pkg::C_LUI: begin
        wr  = 1'b1;
        val = h.imm;
      end
      rvc_pkg::C_AUIPC: begin
        wr  = 1'b1;
        val = pc_q + h.imm;
      end
      rvc_pkg::C_JAL: begin
        wr  = 1'b1;
        val = pc_q + 32'd4;
        npc = pc_q + h.imm;
      end
      rvc_pkg::C_JALR: begin
        wr  = 1'b1;
        val = pc_q + 32'd4;
        npc = {eff[31:1], 1'b0};
      end
      rvc_pkg::C_ECALL: st = rvc_pkg::ST_ECALL;
      rvc_pkg::C_EBREAK: ph_n = (phase_q == 2'd1) ? 2'd2 : 2'd0;
      default: st = rvc_pkg::ST_ILLEGAL;
    endcase

    exec = state_q != S_RD;
    if (!exec) begin
      if (h.cls == rvc_pkg::C_PRELOAD) st = pre_ok ? rvc_pkg::ST_PRELOAD : rvc_pkg::ST_MEM;
      else st = rvc_pkg::ST_HALTED;
    end
    fault = exec && (st == rvc_pkg::ST_ILLEGAL || st == rvc_pkg::ST_MEM);

    state_d    = state_q;
    commit     = 1'b0;
    rd_issue   = 1'b0;
    go_ld      = 1'b0;
    case (state_q)
      S_RD: begin
        if (head_valid_i && !clr_q) begin
          if (h.cls == rvc_pkg::C_PRELOAD || halted_q) begin
            commit = out_free;
          end else begin
            rd_issue = 1'b1;
            state_d  = S_EX;
          end
        end
      end
      S_EX: begin
        if (h.cls == rvc_pkg::C_LOAD && in_win) begin
          go_ld   = 1'b1;
          state_d = S_LD;
        end else if (out_free) begin
          commit  = 1'b1;
          state_d = S_RD;
        end
      end
      S_LD: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = S_RD;
        end
      end
      default: state_d = S_RD;
    endcase
    head_pop_o = commit;
    pre_wr = commit && !exec && h.cls == rvc_pkg::C_PRELOAD && pre_ok;
    st_wr  = commit && exec && h.cls == rvc_pkg::C_STORE && in_win;
  end

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic [7:0]    bank_q [ROWS];
    logic [7:0]    rd_q;
    logic [1:0]    ib;
    logic [RW-1:0] row;
    logic          we;
    logic [RW-1:0] wrow;
    logic [7:0]    wdat;

    always_comb begin
      ib   = 2'(gb) - off32[1:0];
      row  = RW'((off32[AW-1:0] + AW'(ib)) >> 2);
      we   = 1'b0;
      wrow = row;
      wdat = b[8*ib +: 8];
      if (clr_q) begin
        we   = 1'b1;
        wrow = clr_row_q;
        wdat = 8'd0;
      end else if (pre_wr) begin
        we   = pre_off[1:0] == 2'(gb);
        wrow = RW'(pre_off[AW-1:0] >> 2);
        wdat = h.preload_byte;
      end else if (st_wr) begin
        we = {1'b0, ib} < nbytes;
      end
    end

    always_ff @(posedge clk_i) begin
      if (we) bank_q[wrow] <= wdat;
      if (go_ld) rd_q <= bank_q[row];
    end

    assign rdata[gb] = rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      a_raw_q <= rf_q[h.rs1];
      b_raw_q <= rf_q[h.rs2];
    end
    if (go_ld) ld_off_q <= off32[1:0];
    if (commit && exec && !fault && wr && h.rd != 5'd0) rf_q[h.rd] <= val;
    if (commit) begin
      out_q.status           <= st;
      out_q.next_pc          <= (exec && !fault) ? npc : pc_q;
      out_q.reg_write_enable <= exec && !fault && wr && h.rd != 5'd0;
      out_q.reg_write_index  <= (exec && !fault && wr) ? h.rd : 5'd0;
      out_q.reg_write_value  <= (exec && !fault && wr && h.rd != 5'd0) ? val : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RD;
      pc_q        <= 32'd0;
      halted_q    <= 1'b0;
      phase_q     <= 2'd0;
      out_valid_q <= 1'b0;
      rf_valid_q  <= '0;
      a_ok_q      <= 1'b0;
      b_ok_q      <= 1'b0;
      clr_q       <= 1'b1;
      clr_row_q   <= '0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_row_q <= clr_row_q + 1'b1;
        if (clr_row_q == RW'(ROWS - 1)) clr_q <= 1'b0;
      end
      if (rd_issue) begin
        a_ok_q <= rf_valid_q[h.rs1];
        b_ok_q <= rf_valid_q[h.rs2];
      end
      if (commit) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
      if (cfg_pc_we_i) pc_q <= cfg_pc_i;
      if (commit && exec) begin
        if (fault) begin
          halted_q <= 1'b1;
          phase_q  <= 2'd0;
        end else begin
          phase_q <= ph_n;
          pc_q    <= npc;
          if (wr && h.rd != 5'd0) rf_valid_q[h.rd] <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/rvc_checker.sv */
// Port-level checks of the RV32I decode and execute core, bound to its top level.
// Depends on rvc_pkg.
module rvc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input rvc_pkg::result_t result_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("waiting result changed");

  a_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.reg_write_enable |-> result_o.reg_write_index != 5'd0)
    else $error("write to x0 reported");

  a_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (result_o.status == rvc_pkg::ST_ILLEGAL ||
               result_o.status == rvc_pkg::ST_MEM ||
               result_o.status == rvc_pkg::ST_HALTED ||
               result_o.status == rvc_pkg::ST_PRELOAD) |-> !result_o.reg_write_enable)
    else $error("register write on non-retiring item");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> result_o.status != 3'd7)
    else $error("undefined status");

endmodule

bind rv32i_decode_execute_core rvc_checker u_rvc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
